@@ hdl/arpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp responder with address cache
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int CACHE_SLOTS = 16;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int HALF_W = 16;
   localparam int STAT_W = 3;

   localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
   localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
   localparam logic [HALF_W-1:0] OP_REQUEST  = 16'h0001;

   localparam logic FUNC_PACKET = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STS_REPLY     = 3'd0;
   localparam logic [STAT_W-1:0] STS_BAD_HW    = 3'd1;
   localparam logic [STAT_W-1:0] STS_BAD_PROTO = 3'd2;
   localparam logic [STAT_W-1:0] STS_NOT_OURS  = 3'd3;
   localparam logic [STAT_W-1:0] STS_FULL      = 3'd4;
   localparam logic [STAT_W-1:0] STS_BAD_OP    = 3'd5;
   localparam logic [STAT_W-1:0] STS_HIT       = 3'd6;
   localparam logic [STAT_W-1:0] STS_MISS      = 3'd7;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_IP  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_MAC = 1'b1;

   typedef struct packed {
      logic              func;
      logic [HALF_W-1:0] hw_type;
      logic [HALF_W-1:0] proto_type;
      logic [HALF_W-1:0] op_code;
      logic [MAC_W-1:0]  sender_mac;
      logic [IP_W-1:0]   sender_ip;
      logic [IP_W-1:0]   target_ip;
      logic [IP_W-1:0]   query_ip;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              reply_valid;
      logic [MAC_W-1:0]  reply_target_mac;
      logic [IP_W-1:0]   reply_target_ip;
      logic [MAC_W-1:0]  reply_sender_mac;
      logic [IP_W-1:0]   reply_sender_ip;
      logic [MAC_W-1:0]  found_mac;
   } rsp_word_type;

   typedef enum logic [1:0] {
      PM_NOP,
      PM_QUERY,
      PM_PACKET
   } probe_mode_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic             valid;
      probe_mode_type   mode;
      logic [IP_W-1:0]  key_ip;
      logic [MAC_W-1:0] mac;
      logic             ins;
      logic             hit;
      logic             claimed;
      logic [MAC_W-1:0] found_mac;
   } probe_type;

   // end of pass broadcast to all cells
   typedef struct packed {
      logic apply;
      logic commit;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

endpackage

@@ hdl/arp_responder_with_cache_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_with_cache_core
// a word goes from the launch register through the slot cells to the decision,
// which fills the done register, and then to the result register; the probe walks
// the slot chain one cell per cycle, and a new word is taken only once the last
// result has left the done stage; a waiting result holds the next one there, so
// intake stops after one further word until the result word is taken
// reset: synchronous; cache emptied at once, own ip and own mac cleared to 0
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  arpc_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output arpc_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_we,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [arpc_pkg::MAC_W-1:0]       csr_wdata
);
   import arpc_pkg::*;

   // probe taps: tap 0 is the launch register, tap i+1 the output of cell i
   probe_type    probe_tap [CACHE_SLOTS+1];
   cell_ctl_type ctl;

   // control: captures the word, launches the probe and, when the probe drops
   // off the far end, decides the status, commits or drops the tentative
   // insert and queues the result word
   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .launch    (probe_tap[0]),
      .chain_end (probe_tap[CACHE_SLOTS]),
      .ctl       (ctl)
   );

   // slot chain: cell 0 is the lowest slot, so the first free cell met by
   // the probe is the lowest free slot and the first match the lowest match
   // a matching cell refreshes its mac (packet) or reports it (query); the
   // first free cell stores the sender tentatively, made valid at end of
   // pass only when no cell further down matched
   for (genvar gi = 0; gi < CACHE_SLOTS; gi++) begin : g_slot
      arpc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (probe_tap[gi]),
         .ctl       (ctl),
         .probe_out (probe_tap[gi+1])
      );
   end

endmodule

@@ hdl/arpc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cell
// one cache slot; looks at the passing probe, updates itself, forwards it
// ----------------------------------------------------------------------------
module arpc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  arpc_pkg::probe_type    probe_in,
   input  arpc_pkg::cell_ctl_type ctl,
   output arpc_pkg::probe_type    probe_out
);
   import arpc_pkg::*;

   logic             valid_ff, valid_in;
   logic             pending_ff, pending_in;
   logic [IP_W-1:0]  ip_ff, ip_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   probe_type        probe_ff, probe_in_nxt;
   logic             match;
   logic             take_free;

   always_comb begin
      match = probe_in.valid && (probe_in.mode != PM_NOP) && valid_ff
              && (ip_ff == probe_in.key_ip) && !probe_in.hit;
      take_free = probe_in.valid && (probe_in.mode == PM_PACKET) && probe_in.ins
                  && !valid_ff && !probe_in.claimed && !probe_in.hit;

      valid_in     = valid_ff;
      pending_in   = pending_ff;
      ip_in        = ip_ff;
      mac_in       = mac_ff;
      probe_in_nxt = probe_in;

      if (match) begin
         probe_in_nxt.hit = 1'b1;
         if (probe_in.mode == PM_QUERY) begin
            probe_in_nxt.found_mac = mac_ff;
         end else begin
            mac_in = probe_in.mac;
         end
      end

      // tentative insert, made final or dropped at end of pass
      if (take_free) begin
         ip_in                = probe_in.key_ip;
         mac_in               = probe_in.mac;
         pending_in           = 1'b1;
         probe_in_nxt.claimed = 1'b1;
      end

      if (ctl.apply) begin
         if (pending_ff && ctl.commit) begin
            valid_in = 1'b1;
         end
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         pending_ff     <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         probe_ff   <= probe_in_nxt;
      end
      ip_ff  <= ip_in;
      mac_ff <= mac_in;
   end

   assign probe_out = probe_ff;

endmodule

@@ hdl/arpc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// item capture, probe launch, end of pass decision and result register
// ----------------------------------------------------------------------------
module arpc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  arpc_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output arpc_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_we,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arpc_pkg::MAC_W-1:0]          csr_wdata,
   output arpc_pkg::probe_type                 launch,
   input  arpc_pkg::probe_type                 chain_end,
   output arpc_pkg::cell_ctl_type              ctl
);
   import arpc_pkg::*;

   ctrl_state_type   state_ff, state_in;
   req_word_type     item_ff, item_in;
   probe_type        launch_ff, launch_in;
   rsp_word_type     done_ff, done_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IP_W-1:0]  own_ip_ff;
   logic [MAC_W-1:0] own_mac_ff;
   logic             accept;
   logic             fresh;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      launch_in    = launch_ff;
      done_in      = done_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      fresh        = 1'b0;

      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;

      launch_in.valid = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in             = req_word;
               launch_in.valid     = 1'b1;
               launch_in.key_ip    = (req_word.func == FUNC_QUERY) ? req_word.query_ip
                                                                   : req_word.sender_ip;
               launch_in.mac       = req_word.sender_mac;
               launch_in.ins       = (req_word.target_ip == own_ip_ff);
               launch_in.hit       = 1'b0;
               launch_in.claimed   = 1'b0;
               launch_in.found_mac = '0;
               if (req_word.func == FUNC_QUERY) begin
                  launch_in.mode = PM_QUERY;
               end else if (req_word.hw_type == HW_ETHERNET
                            && req_word.proto_type == PROTO_IPV4) begin
                  launch_in.mode = PM_PACKET;
               end else begin
                  launch_in.mode = PM_NOP;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_end.valid) begin
               ctl.apply  = 1'b1;
               ctl.commit = chain_end.claimed && !chain_end.hit;
               fresh      = !chain_end.hit && chain_end.claimed;
               done_in    = '0;
               if (item_ff.func == FUNC_QUERY) begin
                  if (chain_end.hit) begin
                     done_in.status    = STS_HIT;
                     done_in.found_mac = chain_end.found_mac;
                  end else begin
                     done_in.status = STS_MISS;
                  end
               end else if (item_ff.hw_type != HW_ETHERNET) begin
                  done_in.status = STS_BAD_HW;
               end else if (item_ff.proto_type != PROTO_IPV4) begin
                  done_in.status = STS_BAD_PROTO;
               end else if (item_ff.target_ip != own_ip_ff) begin
                  done_in.status = STS_NOT_OURS;
               end else if (!chain_end.hit && !fresh) begin
                  done_in.status = STS_FULL;
               end else if (item_ff.op_code != OP_REQUEST) begin
                  done_in.status = STS_BAD_OP;
               end else begin
                  done_in.status           = STS_REPLY;
                  done_in.reply_valid      = 1'b1;
                  done_in.reply_target_mac = item_ff.sender_mac;
                  done_in.reply_target_ip  = item_ff.sender_ip;
                  done_in.reply_sender_mac = own_mac_ff;
                  done_in.reply_sender_ip  = own_ip_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = done_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         launch_ff.valid <= 1'b0;
         own_ip_ff       <= '0;
         own_mac_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff    <= launch_in;
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_IP:  own_ip_ff  <= csr_wdata[IP_W-1:0];
               CSR_OWN_MAC: own_mac_ff <= csr_wdata;
               default:     ;
            endcase
         end
      end
      item_ff <= item_in;
      done_ff <= done_in;
      rsp_ff  <= rsp_in;
   end

   assign launch    = launch_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

@@ dv/tb_arp_responder_with_cache_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_responder_with_cache_core
// drives parsed arp packets and address queries into the responder, keeps its
// own copy of the address cache and the interface identity, and checks every
// result word field by field in order; a short scripted part comes first,
// then random traffic over several identity settings and idling phases
// ----------------------------------------------------------------------------
module tb_arp_responder_with_cache_core;

   import arpc_pkg::*;

   localparam int POOL_SIZE     = 20;
   localparam int PHASES        = 8;
   localparam int WORDS_A_PHASE = 212;
   localparam int LONG_HOLD     = 600;
   localparam int TAIL_CYCLES   = 40;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [IP_W-1:0]  ALL_IP  = {IP_W{1'b1}};
   localparam logic [MAC_W-1:0] ALL_MAC = {MAC_W{1'b1}};

   // ports of the block
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_word_type           rsp_word;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [MAC_W-1:0]       csr_wdata;

   // shadow of the interface identity and the address cache
   logic [IP_W-1:0]  my_ip;
   logic [MAC_W-1:0] my_mac;
   logic             cache_valid [CACHE_SLOTS];
   logic [IP_W-1:0]  cache_ip    [CACHE_SLOTS];
   logic [MAC_W-1:0] cache_mac   [CACHE_SLOTS];

   // result words still owed by the block, oldest first
   rsp_word_type answers_due [$];
   int           fail_count = 0;

   // sender addresses that recur, so that the cache fills, hits and refreshes
   logic [IP_W-1:0] ip_pool [POOL_SIZE];

   // idling knobs; stall_pct and hold_asks are read by the receiver process
   int idle_pct;
   int stall_pct;
   int hold_asks;
   int hold_seen = 0;
   int hold_left = 0;

   // scripted part: a word with or without a typed answer, or an identity change
   typedef enum logic {
      ROW_WORD,
      ROW_IDENT
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      req_word_type     word;
      logic             typed;
      rsp_word_type     answer;
      logic [IP_W-1:0]  ident_ip;
      logic [MAC_W-1:0] ident_mac;
   } script_row_type;

   script_row_type script [$];

   arp_responder_with_cache_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // cache behaviour
   // ------------------------------------------------------------------------

   // lowest valid slot holding ip, -1 when none
   function automatic int lookup_slot(input logic [IP_W-1:0] ip);
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         if (cache_valid[i] && cache_ip[i] == ip) return i;
      end
      return -1;
   endfunction

   // result word for one accepted request word; updates the cache shadow
   function automatic rsp_word_type resolve_arp(input req_word_type w);
      rsp_word_type r;
      int           hit;
      int           slot;
      r = '0;
      if (w.func == FUNC_QUERY) begin
         hit = lookup_slot(w.query_ip);
         if (hit >= 0) begin
            r.status    = STS_HIT;
            r.found_mac = cache_mac[hit];
         end else begin
            r.status = STS_MISS;
         end
         return r;
      end
      if (w.hw_type != HW_ETHERNET) begin
         r.status = STS_BAD_HW;
         return r;
      end
      if (w.proto_type != PROTO_IPV4) begin
         r.status = STS_BAD_PROTO;
         return r;
      end
      // a known sender is refreshed whatever becomes of the packet
      hit = lookup_slot(w.sender_ip);
      if (hit >= 0) cache_mac[hit] = w.sender_mac;
      if (w.target_ip != my_ip) begin
         r.status = STS_NOT_OURS;
         return r;
      end
      // a new sender is cached before the opcode is looked at
      if (hit < 0) begin
         slot = -1;
         for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (!cache_valid[i]) slot = i;
         end
         if (slot < 0) begin
            r.status = STS_FULL;
            return r;
         end
         cache_valid[slot] = 1'b1;
         cache_ip[slot]    = w.sender_ip;
         cache_mac[slot]   = w.sender_mac;
      end
      if (w.op_code != OP_REQUEST) begin
         r.status = STS_BAD_OP;
         return r;
      end
      r.status           = STS_REPLY;
      r.reply_valid      = 1'b1;
      r.reply_target_mac = w.sender_mac;
      r.reply_target_ip  = w.sender_ip;
      r.reply_sender_mac = my_mac;
      r.reply_sender_ip  = my_ip;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // word builders for the script
   // ------------------------------------------------------------------------

   function automatic req_word_type arp_packet(input logic [HALF_W-1:0] hw,
                                               input logic [HALF_W-1:0] proto,
                                               input logic [HALF_W-1:0] op,
                                               input logic [MAC_W-1:0]  smac,
                                               input logic [IP_W-1:0]   sip,
                                               input logic [IP_W-1:0]   tip);
      req_word_type w;
      w            = '0;
      w.func       = FUNC_PACKET;
      w.hw_type    = hw;
      w.proto_type = proto;
      w.op_code    = op;
      w.sender_mac = smac;
      w.sender_ip  = sip;
      w.target_ip  = tip;
      return w;
   endfunction

   function automatic req_word_type arp_query(input logic [IP_W-1:0] ip);
      req_word_type w;
      w          = '0;
      w.func     = FUNC_QUERY;
      w.query_ip = ip;
      return w;
   endfunction

   function automatic rsp_word_type fixed_answer(input logic [STAT_W-1:0] status,
                                                 input logic [MAC_W-1:0]  tmac,
                                                 input logic [IP_W-1:0]   tip,
                                                 input logic [MAC_W-1:0]  smac,
                                                 input logic [IP_W-1:0]   sip,
                                                 input logic [MAC_W-1:0]  fmac);
      rsp_word_type r;
      r.status           = status;
      r.reply_valid      = (status == STS_REPLY);
      r.reply_target_mac = tmac;
      r.reply_target_ip  = tip;
      r.reply_sender_mac = smac;
      r.reply_sender_ip  = sip;
      r.found_mac        = fmac;
      return r;
   endfunction

   function automatic void add_word(input req_word_type w, input logic typed,
                                    input rsp_word_type answer);
      script_row_type row;
      row.kind      = ROW_WORD;
      row.word      = w;
      row.typed     = typed;
      row.answer    = answer;
      row.ident_ip  = '0;
      row.ident_mac = '0;
      script.push_back(row);
   endfunction

   function automatic void add_ident(input logic [IP_W-1:0] ip,
                                     input logic [MAC_W-1:0] mac);
      script_row_type row;
      row.kind      = ROW_IDENT;
      row.word      = '0;
      row.typed     = 1'b0;
      row.answer    = '0;
      row.ident_ip  = ip;
      row.ident_mac = mac;
      script.push_back(row);
   endfunction

   // random word: mostly well formed traffic around the pool, some noise
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      w.func       = FUNC_PACKET;
      w.hw_type    = HALF_W'($urandom);
      w.proto_type = HALF_W'($urandom);
      w.op_code    = HALF_W'($urandom);
      w.sender_mac = MAC_W'({$urandom, $urandom});
      w.sender_ip  = $urandom;
      w.target_ip  = $urandom;
      w.query_ip   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // lookup, packet fields left as junk
         w.func = FUNC_QUERY;
         if ($urandom_range(0, 99) < 75) w.query_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 88) begin
         w.hw_type    = HW_ETHERNET;
         w.proto_type = PROTO_IPV4;
         if ($urandom_range(0, 99) < 80) w.op_code = OP_REQUEST;
         if ($urandom_range(0, 99) < 90) w.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 99) < 75) w.target_ip = my_ip;
      end else if (pick < 94) begin
         // right hardware type, protocol most likely wrong
         w.hw_type = HW_ETHERNET;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // offer one word, hold it until taken, then log what it should produce
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type answer);
      rsp_word_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // the cache shadow moves on every word, typed answer or not
      predicted = resolve_arp(w);
      answers_due.push_back(typed ? answer : predicted);
   endtask

   // stop offering and wait until every owed word has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // both identity registers, written back to back on an idle block
   task automatic set_identity(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
      csr_we    <= 1'b1;
      csr_index <= CSR_OWN_IP;
      csr_wdata <= MAC_W'(ip);
      @(posedge clock);
      my_ip = ip;
      csr_index <= CSR_OWN_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      my_mac = mac;
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver side
   // ------------------------------------------------------------------------

   task automatic check_answer(input rsp_word_type got);
      rsp_word_type want;
      if (answers_due.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("result word at %0t with nothing owed: %h", $realtime, got);
         return;
      end
      want = answers_due.pop_front();
      if (want.status !== got.status || want.reply_valid !== got.reply_valid
          || want.reply_target_mac !== got.reply_target_mac
          || want.reply_target_ip !== got.reply_target_ip
          || want.reply_sender_mac !== got.reply_sender_mac
          || want.reply_sender_ip !== got.reply_sender_ip
          || want.found_mac !== got.found_mac) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: status exp %0d act %0d, reply_valid exp %0b act %0b",
                     $realtime, want.status, got.status, want.reply_valid, got.reply_valid);
            $display("  reply_target_mac exp %h act %h, reply_target_ip exp %h act %h",
                     want.reply_target_mac, got.reply_target_mac,
                     want.reply_target_ip, got.reply_target_ip);
            $display("  reply_sender_mac exp %h act %h, reply_sender_ip exp %h act %h",
                     want.reply_sender_mac, got.reply_sender_mac,
                     want.reply_sender_ip, got.reply_sender_ip);
            $display("  found_mac exp %h act %h", want.found_mac, got.found_mac);
         end
      end
   endtask

   // takes result words; random stalls plus the long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_answer(rsp_word);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------------

   initial begin
      req_word_type     w;
      logic [IP_W-1:0]  phase_ip;
      logic [MAC_W-1:0] phase_mac;
      int               mode;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      rsp_ready <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= CSR_OWN_IP;
      csr_wdata <= '0;
      stall_pct <= 0;
      hold_asks <= 0;
      idle_pct  = 0;

      // state straight after reset: empty cache, identity cleared
      my_ip  = '0;
      my_mac = '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         cache_valid[i] = 1'b0;
         cache_ip[i]    = '0;
         cache_mac[i]   = '0;
      end
      for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;

      // scripted words, identity still at its reset value of zero
      add_word(arp_query('0), 1'b1, fixed_answer(STS_MISS, '0, '0, '0, '0, '0));
      add_word(arp_packet('0, PROTO_IPV4, OP_REQUEST, '0, '0, '0), 1'b1,
               fixed_answer(STS_BAD_HW, '0, '0, '0, '0, '0));
      add_word(arp_packet('1, PROTO_IPV4, OP_REQUEST, ALL_MAC, ALL_IP, ALL_IP), 1'b1,
               fixed_answer(STS_BAD_HW, '0, '0, '0, '0, '0));
      add_word(arp_packet(HW_ETHERNET, '1, OP_REQUEST, ALL_MAC, ALL_IP, '0), 1'b1,
               fixed_answer(STS_BAD_PROTO, '0, '0, '0, '0, '0));
      add_word(arp_packet(HW_ETHERNET, '0, OP_REQUEST, '0, '0, '0), 1'b1,
               fixed_answer(STS_BAD_PROTO, '0, '0, '0, '0, '0));
      // request for ip zero is ours after reset; reply carries the zero identity
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, ALL_MAC, ALL_IP, '0), 1'b1,
               fixed_answer(STS_REPLY, ALL_MAC, ALL_IP, '0, '0, '0));
      add_word(arp_query(ALL_IP), 1'b1, fixed_answer(STS_HIT, '0, '0, '0, '0, ALL_MAC));
      add_ident(32'hC0A8_0001, 48'h0200_5E10_0001);
      // refresh without reply: known sender, packet no longer ours
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h1234_5678_9ABC,
                          ALL_IP, '0), 1'b1,
               fixed_answer(STS_NOT_OURS, '0, '0, '0, '0, '0));
      add_word(arp_query(ALL_IP), 1'b0, '0);
      // insert then opcode check: reply opcode from a new sender still caches it
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'h0002, '0, '0, 32'hC0A8_0001), 1'b1,
               fixed_answer(STS_BAD_OP, '0, '0, '0, '0, '0));
      add_word(arp_query('0), 1'b0, '0);
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, '1, 48'h0000_0000_0001, '0,
                          32'hC0A8_0001), 1'b1,
               fixed_answer(STS_BAD_OP, '0, '0, '0, '0, '0));
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, '0, ALL_MAC, ALL_IP, 32'hC0A8_0001), 1'b1,
               fixed_answer(STS_BAD_OP, '0, '0, '0, '0, '0));
      add_word(arp_query('0), 1'b0, '0);
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'hA5A5_A5A5_A5A5,
                          32'h0A00_0002, 32'hC0A8_0001), 1'b0, '0);
      // lookup with every packet field set: those fields must not matter
      w = arp_query(32'h0A00_0002);
      w.hw_type    = '1;
      w.proto_type = '1;
      w.op_code    = '1;
      w.sender_mac = ALL_MAC;
      w.sender_ip  = ALL_IP;
      w.target_ip  = ALL_IP;
      add_word(w, 1'b0, '0);
      add_word(arp_query(32'hC0A8_0001), 1'b0, '0);
      // packet with query_ip set: query_ip must not matter
      w = arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h0000_0000_0002,
                     32'h0A00_0003, 32'hC0A8_0001);
      w.query_ip = ALL_IP;
      add_word(w, 1'b0, '0);
      add_ident(ALL_IP, ALL_MAC);
      add_word(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h5A5A_5A5A_5A5A,
                          32'h5A5A_5A5A, ALL_IP), 1'b1,
               fixed_answer(STS_REPLY, 48'h5A5A_5A5A_5A5A, 32'h5A5A_5A5A, ALL_MAC, ALL_IP,
                            '0));
      add_word(arp_query(32'h5A5A_5A5A), 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_IDENT) begin
            drain();
            set_identity(script[i].ident_ip, script[i].ident_mac);
         end else begin
            send_word(script[i].word, script[i].typed, script[i].answer);
         end
      end

      // random phases: identity changes between phases, idling by phase
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p % 3)
            0:       phase_ip = $urandom;
            1:       phase_ip = '0;
            default: phase_ip = ALL_IP;
         endcase
         case ((p + 1) % 3)
            0:       phase_mac = MAC_W'({$urandom, $urandom});
            1:       phase_mac = '0;
            default: phase_mac = ALL_MAC;
         endcase
         set_identity(phase_ip, phase_mac);
         mode = p % 4;
         idle_pct = (mode == 1) ? 45 : (mode == 3) ? 7 : 0;
         stall_pct <= (mode == 2) ? 45 : (mode == 3) ? 7 : 0;
         for (int n = 0; n < WORDS_A_PHASE; n++) begin
            // long receiver hold-off while words keep coming, so intake backs up
            if (p == 0 && n == 50) hold_asks <= hold_asks + 1;
            send_word(random_word(), 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && answers_due.size() == 0) begin
         $display("tb_arp_responder_with_cache_core OK");
      end else begin
         $display("tb_arp_responder_with_cache_core NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_400_000;
      $display("tb_arp_responder_with_cache_core NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/arpc_pkg.sv
hdl/arpc_cell.sv
hdl/arpc_ctrl.sv
hdl/arp_responder_with_cache_core.sv
dv/tb_arp_responder_with_cache_core.sv
